@@ hdl/rlpc_pkg.sv @@
// shared types and constants for the run-length pair/count encoder
// no dependencies; imported by rlpc_core, rlpc_outq and the top level
package rlpc_pkg;

  localparam logic [7:0] RUN_LIMIT_DEF = 8'd255;
  localparam int unsigned OUTQ_DEPTH = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LIT  = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       item_done;
    logic       block_done;
  } result_t;

  // results caused by one request: count, then up to two entries in order
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } enc_out_t;

endpackage

@@ hdl/rlpc_core.sv @@
// encoder state (phase, held byte, repeat count) and per-request result logic
// depends on rlpc_pkg
module rlpc_core #(
  parameter logic [7:0] RUN_LIMIT = rlpc_pkg::RUN_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              block_end,
  output rlpc_pkg::enc_out_t enc
);
  import rlpc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [8:0] cnt_inc;
  logic       same;
  logic       hit_limit;

  assign cnt_inc   = {1'b0, cnt_r} + 9'd1;
  assign same      = (data_byte == held_r);
  assign hit_limit = (cnt_inc >= {1'b0, RUN_LIMIT});

  // next state
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      PH_LIT: begin
        if (same) begin
          cnt_nxt   = 8'd0;
          phase_nxt = block_end ? PH_IDLE : PH_RUN;
        end else begin
          held_nxt  = data_byte;
          phase_nxt = block_end ? PH_IDLE : PH_LIT;
        end
      end
      PH_RUN: begin
        if (same && !block_end) begin
          if (hit_limit) begin
            cnt_nxt   = 8'd0;
            phase_nxt = PH_IDLE;
          end else begin
            cnt_nxt = cnt_inc[7:0];
          end
        end else begin
          cnt_nxt   = 8'd0;
          held_nxt  = data_byte;
          phase_nxt = block_end ? PH_IDLE : PH_LIT;
        end
      end
      default: begin
        held_nxt  = data_byte;
        phase_nxt = block_end ? PH_IDLE : PH_LIT;
      end
    endcase
  end

  // results
  always_comb begin
    enc.num  = 2'd1;
    enc.res0 = '{code_byte: data_byte, item_done: 1'b1, block_done: block_end};
    enc.res1 = '{code_byte: data_byte, item_done: 1'b1, block_done: block_end};
    unique case (phase_r)
      PH_RUN: begin
        if (same && !block_end) begin
          // limit reached: count goes out alone, otherwise nothing
          enc.num  = hit_limit ? 2'd1 : 2'd0;
          enc.res0 = '{code_byte: cnt_inc[7:0], item_done: 1'b1, block_done: 1'b0};
        end else begin
          enc.num  = 2'd2;
          enc.res0 = '{code_byte: cnt_r, item_done: 1'b0, block_done: 1'b0};
        end
      end
      default: begin
        enc.num = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/rlpc_outq.sv @@
// three-entry result queue, up to two writes per cycle, head is the output register
// depends on rlpc_pkg
module rlpc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlpc_pkg::enc_out_t enc,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output rlpc_pkg::result_t  head
);
  import rlpc_pkg::*;

  localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

  result_t       q_r   [OUTQ_DEPTH];
  result_t       q_nxt [OUTQ_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base;
  logic [CW-1:0] n_in;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - CW'(pop);
  // at least two free entries after this cycle's pop
  assign room      = (base <= CW'(OUTQ_DEPTH - 2));
  assign n_in      = push ? CW'(enc.num) : '0;
  assign cnt_nxt   = base + n_in;
  assign head      = q_r[0];

  always_comb begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      if (push && (enc.num != 2'd0) && (CW'(i) == base)) begin
        q_nxt[i] = enc.res0;
      end
      if (push && (enc.num == 2'd2) && (CW'(i) == base + CW'(1))) begin
        q_nxt[i] = enc.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

@@ hdl/run_length_pair_count_encoder_unit.sv @@
// run-length pair/count encoder: input register, encoder logic, result queue
// a request waits in the input register until the result queue has room for its results
// throughput: one request per cycle while the result queue has room; a request with two
// results costs an extra output transfer through the single output register at the head of the result queue
// reset: synchronous active-low rst_n empties all stages and returns to idle
// depends on rlpc_pkg, rlpc_core, rlpc_outq
module run_length_pair_count_encoder_unit #(
  parameter logic [7:0] RUN_LIMIT = rlpc_pkg::RUN_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_item_done,
  output logic       out_block_done
);
  import rlpc_pkg::*;

  logic       st_valid_r;
  logic [7:0] st_data_r;
  logic       st_last_r;
  logic       room;
  logic       adv;
  enc_out_t   enc;
  result_t    head;

  assign adv      = st_valid_r && room;
  assign in_ready = !st_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_data_r <= in_data_byte;
      st_last_r <= in_block_end;
    end
  end

  rlpc_core #(
    .RUN_LIMIT(RUN_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (adv),
    .data_byte (st_data_r),
    .block_end (st_last_r),
    .enc       (enc)
  );

  rlpc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .enc       (enc),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_code_byte  = head.code_byte;
  assign out_item_done  = head.item_done;
  assign out_block_done = head.block_done;

endmodule

@@ tb/rlpc_code_checker.sv @@
`timescale 1ns / 100ps
// result checker for the run-length pair/count encoder: predicts the code stream
// from accepted requests and compares every accepted result in order
// depends on rlpc_pkg
module rlpc_code_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_code_byte,
  input  logic       out_item_done,
  input  logic       out_block_done,
  output int         fail_count,
  output int         pending
);
  import rlpc_pkg::*;

  phase_t     enc_phase = PH_IDLE;
  logic [7:0] held_byte = '0;
  logic [7:0] run_count = '0;
  result_t    code_q[$];
  result_t    want;
  int         n_fail = 0;
  int         n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  task automatic push_code(input logic [7:0] code, input logic item, input logic blk);
    result_t r;
    r.code_byte  = code;
    r.item_done  = item;
    r.block_done = blk;
    code_q.push_back(r);
  endtask

  task automatic emit_literal(input logic [7:0] b, input logic last);
    push_code(b, 1'b1, last);
    if (last) begin
      enc_phase = PH_IDLE;
    end else begin
      held_byte = b;
      enc_phase = PH_LIT;
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    case (enc_phase)
      PH_LIT: begin
        if (b == held_byte) begin
          // second byte of a pair goes out as is, counting starts
          push_code(b, 1'b1, last);
          run_count = '0;
          enc_phase = last ? PH_IDLE : PH_RUN;
        end else begin
          emit_literal(b, last);
        end
      end
      PH_RUN: begin
        if (b == held_byte && !last) begin
          run_count = run_count + 8'd1;
          if (run_count >= RUN_LIMIT_DEF) begin
            push_code(run_count, 1'b1, 1'b0);
            run_count = '0;
            enc_phase = PH_IDLE;
          end
        end else begin
          // count so far, then this byte as a fresh literal
          push_code(run_count, 1'b0, 1'b0);
          run_count = '0;
          emit_literal(b, last);
        end
      end
      default: emit_literal(b, last);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      enc_phase = PH_IDLE;
      held_byte = '0;
      run_count = '0;
      code_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result code=%02h item_done=%b block_done=%b",
                     $realtime, out_code_byte, out_item_done, out_block_done);
        end else begin
          want = code_q.pop_front();
          if (out_code_byte !== want.code_byte || out_item_done !== want.item_done ||
              out_block_done !== want.block_done) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch exp code=%02h item=%b blk=%b, got %02h %b %b",
                       $realtime, want.code_byte, want.item_done, want.block_done,
                       out_code_byte, out_item_done, out_block_done);
          end
        end
      end
      if (in_valid && in_ready)
        encode_byte(in_data_byte, in_block_end);
    end
    n_pending = code_q.size();
  end

endmodule

@@ tb/run_length_pair_count_encoder_unit_test.sv @@
`timescale 1ns / 100ps
// top of the run-length pair/count encoder testbench: clock, reset, request
// stimulus, output flow control and verdict; depends on rlpc_pkg, rlpc_code_checker
module run_length_pair_count_encoder_unit_test;
  import rlpc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 600;
  localparam int N_DIRECTED  = 21;

  // {block_end, data_byte}
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    {1'b1, 8'h00},
    {1'b1, 8'hFF},
    {1'b0, 8'hA5}, {1'b1, 8'hA5},
    {1'b0, 8'h3C}, {1'b0, 8'h3C}, {1'b0, 8'h3C}, {1'b0, 8'h3C}, {1'b1, 8'h7E},
    {1'b0, 8'h11}, {1'b0, 8'h11}, {1'b1, 8'h11},
    {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b1, 8'h80},
    {1'b0, 8'h55}, {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b0, 8'hAA}, {1'b0, 8'hAA},
    {1'b1, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = '0;
  logic       in_block_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_code_byte;
  logic       out_item_done;
  logic       out_block_done;
  int         fail_count;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         rx_hold = 1'b0;
  int         quiet_cycles = 0;

  always #4 clk = ~clk;

  run_length_pair_count_encoder_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_item_done (out_item_done),
    .out_block_done(out_block_done)
  );

  rlpc_code_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_item_done (out_item_done),
    .out_block_done(out_block_done),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // result side flow control, with one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL run_length_pair_count_encoder_unit");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_block_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly blocks built from runs, some stray requests with random block ends
  task automatic send_random_stream(input int n_items);
    int         sent;
    int         n_runs;
    int         run_len;
    int         r;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_byte(8'($urandom), $urandom_range(99) < 25);
        sent++;
      end else begin
        n_runs = $urandom_range(1, 6);
        for (int i = 0; i < n_runs; i++) begin
          r = $urandom_range(99);
          if (r < 10)      b = 8'h00;
          else if (r < 20) b = 8'hFF;
          else if (r < 45) b = 8'($urandom_range(3)); // neighbors often equal
          else             b = 8'($urandom);
          r = $urandom_range(99);
          if (r < 60)      run_len = 1;
          else if (r < 90) run_len = $urandom_range(2, 6);
          else if (r < 97) run_len = $urandom_range(7, 40);
          else             run_len = $urandom_range(250, 520); // can cross the count limit
          for (int k = 0; k < run_len; k++) begin
            send_byte(b, (i == n_runs - 1) && (k == run_len - 1));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 27;
    rx_idle_pct = 55;
    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 27 : (p == 1) ? 55 : 0;
      rx_idle_pct = (p == 0) ? 55 : (p == 1) ? 27 : 0;
      if (p == 2) begin
        // stall the result side while requests keep coming
        @(posedge clk);
        rx_hold = 1'b1;
        @(negedge clk);
      end
      send_random_stream(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS run_length_pair_count_encoder_unit");
    else
      $display("FAIL run_length_pair_count_encoder_unit");
    $finish;
  end

endmodule
